FILE: design/kpd_pkg.sv
// ----------------------------------------------------------------------------
// kpd_pkg
// Types and constants shared by the key press duration classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package kpd_pkg;

   localparam int KEY_W   = 5;
   localparam int FLAG_W  = 6;
   localparam int TICK_W  = 16;
   localparam int CSR_IDX_W = 3;

   // event flag bit positions
   localparam int FLAG_7S    = 0;
   localparam int FLAG_3S    = 1;
   localparam int FLAG_2S    = 2;
   localparam int FLAG_1S    = 3;
   localparam int FLAG_SHORT = 4;
   localparam int FLAG_POP   = 5;

   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   typedef enum logic [1:0] {
      ST_NONE    = 2'd0,
      ST_PUSHED  = 2'd1,
      ST_POPPED  = 2'd2,
      ST_TIMEOUT = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHORT   = 3'd0,
      CSR_LONG1   = 3'd1,
      CSR_LONG2   = 3'd2,
      CSR_LONG3   = 3'd3,
      CSR_LONG7   = 3'd4,
      CSR_TIMEOUT = 3'd5
   } csr_index_type;

   typedef enum logic {
      OP_SCAN  = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   typedef struct packed {
      logic [TICK_W-1:0] short_ticks;
      logic [TICK_W-1:0] long1_ticks;
      logic [TICK_W-1:0] long2_ticks;
      logic [TICK_W-1:0] long3_ticks;
      logic [TICK_W-1:0] long7_ticks;
      logic [TICK_W-1:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      status_type        status;
      logic [KEY_W-1:0]  held;
      logic [KEY_W-1:0]  released;
      logic [TICK_W-1:0] ticks;
      logic [FLAG_W-1:0] events;
   } press_state_type;

   typedef struct packed {
      op_type            op;
      logic [KEY_W-1:0]  keys;
      logic [FLAG_W-1:0] mask;
   } req_type;

endpackage

`default_nettype wire

FILE: design/kpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// kpd_cfg_regs
// Threshold register file, written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_cfg_regs (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [kpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [kpd_pkg::TICK_W-1:0]     csr_wdata,
   output kpd_pkg::cfg_type                    cfg
);

   kpd_pkg::cfg_type cfg_ff;
   kpd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (kpd_pkg::csr_index_type'(csr_index))
            kpd_pkg::CSR_SHORT:   cfg_in.short_ticks   = csr_wdata;
            kpd_pkg::CSR_LONG1:   cfg_in.long1_ticks   = csr_wdata;
            kpd_pkg::CSR_LONG2:   cfg_in.long2_ticks   = csr_wdata;
            kpd_pkg::CSR_LONG3:   cfg_in.long3_ticks   = csr_wdata;
            kpd_pkg::CSR_LONG7:   cfg_in.long7_ticks   = csr_wdata;
            kpd_pkg::CSR_TIMEOUT: cfg_in.timeout_ticks = csr_wdata;
            default:              cfg_in = cfg_ff;   // drop writes past the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_ticks   <= 16'd3;
         cfg_ff.long1_ticks   <= 16'd100;
         cfg_ff.long2_ticks   <= 16'd200;
         cfg_ff.long3_ticks   <= 16'd300;
         cfg_ff.long7_ticks   <= 16'd700;
         cfg_ff.timeout_ticks <= 16'd800;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: design/kpd_next_state.sv
// ----------------------------------------------------------------------------
// kpd_next_state
// One-item state update: press tracking, tick count, threshold flags, flag clear.
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_next_state (
   input  wire kpd_pkg::req_type          req,
   input  wire kpd_pkg::cfg_type          cfg,
   input  wire kpd_pkg::press_state_type  cur,
   output kpd_pkg::press_state_type       nxt,
   output logic                           mask_all_set
);

   kpd_pkg::press_state_type mid;
   logic [kpd_pkg::TICK_W-1:0] tick_inc;

   // key change handling
   always_comb begin
      mid = cur;
      if (req.keys != cur.held) begin
         if (req.keys != '0 && cur.held != '0) begin
            // second key while held: cancel the press, keep held keys
            mid.status = kpd_pkg::ST_NONE;
            mid.ticks  = '0;
         end else if (req.keys != '0) begin
            mid.held   = req.keys;
            mid.status = kpd_pkg::ST_PUSHED;
            mid.ticks  = '0;
            mid.events = '0;
         end else begin
            mid.released = cur.held;
            mid.held     = '0;
            if (cur.ticks > cfg.short_ticks) begin
               mid.status = kpd_pkg::ST_POPPED;
               mid.events[kpd_pkg::FLAG_POP] = 1'b1;
            end else begin
               mid.status = kpd_pkg::ST_NONE;
            end
         end
      end
   end

   // saturating count
   assign tick_inc = (mid.ticks == kpd_pkg::TICK_MAX) ? mid.ticks
                                                      : mid.ticks + 1'b1;

   always_comb begin
      nxt = cur;
      if (req.op == kpd_pkg::OP_CLEAR) begin
         nxt.events = cur.events & ~req.mask;
      end else begin
         nxt = mid;
         if (mid.status == kpd_pkg::ST_PUSHED) begin
            nxt.ticks = tick_inc;
            priority if (tick_inc == cfg.long7_ticks) nxt.events[kpd_pkg::FLAG_7S]    = 1'b1;
            else if (tick_inc == cfg.long3_ticks)     nxt.events[kpd_pkg::FLAG_3S]    = 1'b1;
            else if (tick_inc == cfg.long2_ticks)     nxt.events[kpd_pkg::FLAG_2S]    = 1'b1;
            else if (tick_inc == cfg.long1_ticks)     nxt.events[kpd_pkg::FLAG_1S]    = 1'b1;
            else if (tick_inc == cfg.short_ticks)     nxt.events[kpd_pkg::FLAG_SHORT] = 1'b1;
            else                                      nxt.events = mid.events;
            if (tick_inc > cfg.timeout_ticks) begin
               nxt.status = kpd_pkg::ST_TIMEOUT;
            end
         end
      end
   end

   assign mask_all_set = ((nxt.events & req.mask) == req.mask);

endmodule

`default_nettype wire

FILE: design/key_press_duration_classifier.sv
// ----------------------------------------------------------------------------
// key_press_duration_classifier
// Long-press detector for a small key pad: tracks one press per scan tick,
// raises sticky duration flags and reports state after every item.
// ----------------------------------------------------------------------------
//
//   channel | ports                          | direction | moves
//   --------+--------------------------------+-----------+--------------------
//   req     | req_valid/req_ready + fields   | in        | one scan or clear item
//   rsp     | rsp_valid/rsp_ready + fields   | out       | one status item
//   csr     | csr_we, csr_index, csr_wdata   | in        | threshold write
//
// Flow: an item is taken into the input register; the state update and the
// result register load follow once the rsp stage is free. One item per cycle
// sustained while rsp_ready stays high.
// Reset: synchronous, clears press state and pipeline valids and loads the
// default thresholds.
// Stalls: a held rsp stage stops the update; the input register still takes
// one item, after which req_ready drops until rsp_ready returns.
//
`default_nettype none

module key_press_duration_classifier #(
   parameter int KEY_COUNT = 5
) (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_op,
   input  wire logic [kpd_pkg::KEY_W-1:0]      req_key_vector,
   input  wire logic [kpd_pkg::FLAG_W-1:0]     req_flag_mask,

   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [1:0]                          rsp_key_status,
   output logic [kpd_pkg::KEY_W-1:0]           rsp_pressed_keys,
   output logic [kpd_pkg::KEY_W-1:0]           rsp_released_keys,
   output logic [kpd_pkg::TICK_W-1:0]          rsp_press_ticks,
   output logic [kpd_pkg::FLAG_W-1:0]          rsp_event_bits,
   output logic                                rsp_mask_all_set,

   input  wire logic                           csr_we,
   input  wire logic [kpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [kpd_pkg::TICK_W-1:0]     csr_wdata
);

   // keys beyond KEY_COUNT never count as pressed
   localparam int KEYS_USED = (KEY_COUNT < kpd_pkg::KEY_W) ? KEY_COUNT : kpd_pkg::KEY_W;
   localparam logic [kpd_pkg::KEY_W-1:0] KEY_MASK =
      kpd_pkg::KEY_W'((32'd1 << KEYS_USED) - 32'd1);

   kpd_pkg::cfg_type          cfg;
   kpd_pkg::req_type          req_ff;
   kpd_pkg::req_type          req_in;
   logic                      req_valid_ff;
   kpd_pkg::press_state_type  state_ff;
   kpd_pkg::press_state_type  state_in;
   logic                      mask_all_in;
   kpd_pkg::press_state_type  rsp_ff;
   logic                      rsp_mask_ff;
   logic                      rsp_valid_ff;
   logic                      advance;
   logic                      req_take;

   kpd_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kpd_next_state u_next (
      .req          (req_ff),
      .cfg          (cfg),
      .cur          (state_ff),
      .nxt          (state_in),
      .mask_all_set (mask_all_in)
   );

   // move the buffered item into the result register when it is free
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign req_in.op   = kpd_pkg::op_type'(req_op);
   assign req_in.keys = req_key_vector & KEY_MASK;
   assign req_in.mask = req_flag_mask;

   // control: valids and press state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload: hold until the next load
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff      <= state_in;
         rsp_mask_ff <= mask_all_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_key_status    = rsp_ff.status;
   assign rsp_pressed_keys  = rsp_ff.held;
   assign rsp_released_keys = rsp_ff.released;
   assign rsp_press_ticks   = rsp_ff.ticks;
   assign rsp_event_bits    = rsp_ff.events;
   assign rsp_mask_all_set  = rsp_mask_ff;

`ifndef NO_ASSERTIONS
   // a press in progress always has keys held and at least one tick
   a_pushed_has_keys: assert property (@(posedge clock) disable iff (reset)
      (state_ff.status == kpd_pkg::ST_PUSHED || state_ff.status == kpd_pkg::ST_TIMEOUT)
      |-> (state_ff.held != '0 && state_ff.ticks != '0))
      else $error("pushed or timed-out press without keys or ticks");

   // the result register mirrors the state written at the same edge
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_ff == state_ff))
      else $error("result register out of step with press state");

   // input buffer is full whenever the channel is blocked
   a_blocked_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (req_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("req_ready low without a stalled item");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_key_press_duration_classifier.sv
// ----------------------------------------------------------------------------
// tb_key_press_duration_classifier
// Self-checking bench for the key press duration classifier. A clocked driver
// feeds scan and clear items from a queue, a clocked monitor checks every
// status item against a cycle-free predictor of the press state. Thresholds
// move through defaults, small distinct values, equal values that test the
// flag priority, the range extremes and random small values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_key_press_duration_classifier;

   localparam int unsigned CYCLE_LIMIT = 200_000;
   localparam int unsigned HOLD_CYCLES = 150;
   localparam int unsigned MAX_SHOWN   = 10;

   // one expected or observed status item
   typedef struct packed {
      kpd_pkg::status_type        status;
      logic [kpd_pkg::KEY_W-1:0]  held;
      logic [kpd_pkg::KEY_W-1:0]  released;
      logic [kpd_pkg::TICK_W-1:0] ticks;
      logic [kpd_pkg::FLAG_W-1:0] events;
      logic                       all_set;
   } press_report_type;

   // -------------------------------------------------------------------------
   // clock, reset and block ports
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_ready;
   kpd_pkg::req_type              offered   = '0;
   logic                          req_op;
   logic [kpd_pkg::KEY_W-1:0]     req_key_vector;
   logic [kpd_pkg::FLAG_W-1:0]    req_flag_mask;

   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [1:0]                    rsp_key_status;
   logic [kpd_pkg::KEY_W-1:0]     rsp_pressed_keys;
   logic [kpd_pkg::KEY_W-1:0]     rsp_released_keys;
   logic [kpd_pkg::TICK_W-1:0]    rsp_press_ticks;
   logic [kpd_pkg::FLAG_W-1:0]    rsp_event_bits;
   logic                          rsp_mask_all_set;

   logic                          csr_we    = 1'b0;
   kpd_pkg::csr_index_type        csr_index = kpd_pkg::CSR_SHORT;
   logic [kpd_pkg::TICK_W-1:0]    csr_wdata = '0;

   // the payload ports simply mirror the item on offer
   assign req_op         = offered.op;
   assign req_key_vector = offered.keys;
   assign req_flag_mask  = offered.mask;

   initial begin
      forever #5 clock = !clock;
   end

   key_press_duration_classifier u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_key_vector    (req_key_vector),
      .req_flag_mask     (req_flag_mask),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_key_status    (rsp_key_status),
      .rsp_pressed_keys  (rsp_pressed_keys),
      .rsp_released_keys (rsp_released_keys),
      .rsp_press_ticks   (rsp_press_ticks),
      .rsp_event_bits    (rsp_event_bits),
      .rsp_mask_all_set  (rsp_mask_all_set),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // press state predictor
   // Thresholds start at the reset defaults and track every write; the press
   // state starts cleared, the same as the block after reset.
   // -------------------------------------------------------------------------
   logic [kpd_pkg::TICK_W-1:0] limit_ticks [6] = '{16'd3, 16'd100, 16'd200, 16'd300,
                                                   16'd700, 16'd800};
   logic [kpd_pkg::KEY_W-1:0]  pad_held     = '0;
   logic [kpd_pkg::KEY_W-1:0]  pad_released = '0;
   kpd_pkg::status_type        pad_status   = kpd_pkg::ST_NONE;
   logic [kpd_pkg::TICK_W-1:0] pad_ticks    = '0;
   logic [kpd_pkg::FLAG_W-1:0] pad_events   = '0;

   press_report_type  report_queue [$];
   kpd_pkg::req_type  pending [$];

   int unsigned items_sent      = 0;
   int unsigned reports_checked = 0;
   int unsigned mismatch_count  = 0;
   int unsigned pop_count       = 0;
   int unsigned timeout_count   = 0;
   int unsigned cancel_count    = 0;
   int unsigned setting_count   = 1;

   // Work out the status item that one accepted item must produce.
   function automatic void advance_press_state(kpd_pkg::req_type it);
      press_report_type rpt;
      logic             cancelled;
      cancelled = 1'b0;
      items_sent++;
      if (it.op == kpd_pkg::OP_CLEAR) begin
         pad_events &= ~it.mask;
      end else if (it.keys != pad_held) begin
         if (it.keys != '0 && pad_held != '0) begin
            // another key while one is held: drop the press, keep the held vector
            pad_status = kpd_pkg::ST_NONE;
            pad_ticks  = '0;
            cancelled  = 1'b1;
            cancel_count++;
         end else begin
            if (it.keys == '0)
               pad_released = pad_held;
            pad_held = it.keys;
            if (it.keys != '0) begin
               pad_status = kpd_pkg::ST_PUSHED;
               pad_ticks  = '0;
               pad_events = '0;
            end else if (pad_ticks > limit_ticks[kpd_pkg::CSR_SHORT]) begin
               pad_status = kpd_pkg::ST_POPPED;
               pad_events[kpd_pkg::FLAG_POP] = 1'b1;
               pop_count++;
            end else begin
               pad_status = kpd_pkg::ST_NONE;
            end
         end
      end
      if (it.op == kpd_pkg::OP_SCAN && !cancelled && pad_status == kpd_pkg::ST_PUSHED) begin
         if (pad_ticks != kpd_pkg::TICK_MAX)
            pad_ticks = pad_ticks + 1'b1;
         // first matching threshold wins; a zero threshold never matches
         if (pad_ticks == limit_ticks[kpd_pkg::CSR_LONG7])
            pad_events[kpd_pkg::FLAG_7S] = 1'b1;
         else if (pad_ticks == limit_ticks[kpd_pkg::CSR_LONG3])
            pad_events[kpd_pkg::FLAG_3S] = 1'b1;
         else if (pad_ticks == limit_ticks[kpd_pkg::CSR_LONG2])
            pad_events[kpd_pkg::FLAG_2S] = 1'b1;
         else if (pad_ticks == limit_ticks[kpd_pkg::CSR_LONG1])
            pad_events[kpd_pkg::FLAG_1S] = 1'b1;
         else if (pad_ticks == limit_ticks[kpd_pkg::CSR_SHORT])
            pad_events[kpd_pkg::FLAG_SHORT] = 1'b1;
         if (pad_ticks > limit_ticks[kpd_pkg::CSR_TIMEOUT]) begin
            pad_status = kpd_pkg::ST_TIMEOUT;
            timeout_count++;
         end
      end
      rpt.status   = pad_status;
      rpt.held     = pad_held;
      rpt.released = pad_released;
      rpt.ticks    = pad_ticks;
      rpt.events   = pad_events;
      rpt.all_set  = ((pad_events & it.mask) == it.mask);
      report_queue.push_back(rpt);
   endfunction

   function automatic string describe_report(press_report_type r);
      return $sformatf("status %0d held %h released %h ticks %0d events %h all_set %b",
                       r.status, r.held, r.released, r.ticks, r.events, r.all_set);
   endfunction

   function automatic void log_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN)
         $display("ERROR: %s", msg);
   endfunction

   // -------------------------------------------------------------------------
   // driver: offer queued items, hold each until accepted, then idle for a
   // drawn number of cycles; quiet stretches send back to back
   // -------------------------------------------------------------------------
   int unsigned send_wait  = 0;
   logic        send_quiet = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_valid && req_ready)
            advance_press_state(offered);
         if (!req_valid || req_ready) begin
            if (send_wait != 0) begin
               req_valid <= 1'b0;
               send_wait <= send_wait - 1;
            end else if (pending.size() != 0) begin
               offered   <= pending.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 24) == 0)
                  send_quiet = !send_quiet;
               send_wait <= send_quiet ? 0 : $urandom_range(0, 13);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // monitor: check each status item against the oldest expectation, then
   // stall for a drawn number of cycles
   // -------------------------------------------------------------------------
   int unsigned recv_stall = 0;
   logic        recv_quiet = 1'b0;
   int unsigned hold_left  = 0;
   logic        hold_kick  = 1'b0;

   always @(posedge clock) begin : rsp_side
      press_report_type seen;
      press_report_type want;
      int unsigned      stall_next;
      if (reset) begin
         rsp_ready  <= 1'b0;
         recv_stall <= 0;
      end else begin
         stall_next = recv_stall;
         if (rsp_valid && rsp_ready) begin
            seen.status   = kpd_pkg::status_type'(rsp_key_status);
            seen.held     = rsp_pressed_keys;
            seen.released = rsp_released_keys;
            seen.ticks    = rsp_press_ticks;
            seen.events   = rsp_event_bits;
            seen.all_set  = rsp_mask_all_set;
            reports_checked++;
            if (report_queue.size() == 0) begin
               log_failure({"status item with nothing expected: ", describe_report(seen)});
            end else begin
               want = report_queue.pop_front();
               if (seen !== want)
                  log_failure($sformatf("status item %0d\n  expected %s\n  actual   %s",
                                        reports_checked, describe_report(want),
                                        describe_report(seen)));
            end
            if ($urandom_range(0, 24) == 0)
               recv_quiet = !recv_quiet;
            stall_next = recv_quiet ? 0 : $urandom_range(0, 13);
         end else if (stall_next != 0) begin
            stall_next = stall_next - 1;
         end
         recv_stall <= stall_next;
         rsp_ready  <= (stall_next == 0) && (hold_left == 0);
      end
   end

   // long receiver hold-off, counted here so the sender keeps offering and
   // the block backs up into its input
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_kick)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // watchdog
   int unsigned cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d status items outstanding",
                  cycle_count, report_queue.size());
         $display("status: fail");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // stimulus helpers
   // -------------------------------------------------------------------------
   function automatic void push_item(kpd_pkg::op_type op,
                                     logic [kpd_pkg::KEY_W-1:0] keys,
                                     logic [kpd_pkg::FLAG_W-1:0] mask);
      kpd_pkg::req_type it;
      it.op   = op;
      it.keys = keys;
      it.mask = mask;
      pending.push_back(it);
   endfunction

   // empty, full or random test mask
   function automatic logic [kpd_pkg::FLAG_W-1:0] pick_mask();
      unique case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return kpd_pkg::FLAG_W'($urandom_range(0, 63));
      endcase
   endfunction

   // mostly one key, sometimes a chord
   function automatic logic [kpd_pkg::KEY_W-1:0] pick_keys();
      if ($urandom_range(0, 9) < 7)
         return kpd_pkg::KEY_W'(1) << $urandom_range(0, kpd_pkg::KEY_W - 1);
      return kpd_pkg::KEY_W'($urandom_range(1, 31));
   endfunction

   // Queue well-formed presses of random length with clears, cancels and
   // stray items mixed in.
   function automatic void queue_presses(int unsigned count);
      int unsigned               goal;
      int unsigned               span;
      int unsigned               hold;
      logic [kpd_pkg::KEY_W-1:0] keys;
      logic [kpd_pkg::KEY_W-1:0] other;
      goal = pending.size() + count;
      // press lengths reach just past the timeout, capped for long settings
      span = (limit_ticks[kpd_pkg::CSR_TIMEOUT] < 30) ?
             limit_ticks[kpd_pkg::CSR_TIMEOUT] + 4 : 30;
      while (pending.size() < goal) begin
         if ($urandom_range(0, 9) == 0) begin
            push_item(kpd_pkg::op_type'($urandom_range(0, 1)),
                      kpd_pkg::KEY_W'($urandom_range(0, 31)), pick_mask());
            continue;
         end
         keys = pick_keys();
         push_item(kpd_pkg::OP_SCAN, keys, pick_mask());
         hold = $urandom_range(0, span);
         for (int unsigned n = 0; n < hold; n++) begin
            if ($urandom_range(0, 11) == 0)
               push_item(kpd_pkg::OP_CLEAR, kpd_pkg::KEY_W'($urandom_range(0, 31)),
                         pick_mask());
            else if ($urandom_range(0, 39) == 0)
               push_item(kpd_pkg::OP_SCAN, keys ^ pick_keys() | kpd_pkg::KEY_W'(1),
                         pick_mask());
            push_item(kpd_pkg::OP_SCAN, keys, pick_mask());
         end
         // release, sometimes by way of a second key
         if ($urandom_range(0, 5) == 0) begin
            other = pick_keys();
            push_item(kpd_pkg::OP_SCAN, (other == keys) ? ~keys : other, pick_mask());
         end
         push_item(kpd_pkg::OP_SCAN, '0, pick_mask());
         repeat ($urandom_range(0, 2))
            push_item(kpd_pkg::OP_SCAN, '0, pick_mask());
      end
   endfunction

   // Wait until the queue is empty, nothing is offered and every expected
   // status item is in, then let the pipeline settle.
   task automatic wait_for_drain();
      while (pending.size() != 0 || req_valid || report_queue.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_threshold(kpd_pkg::csr_index_type idx,
                                  logic [kpd_pkg::TICK_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      limit_ticks[idx] = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_thresholds(logic [kpd_pkg::TICK_W-1:0] t_short,
                                   logic [kpd_pkg::TICK_W-1:0] t_long1,
                                   logic [kpd_pkg::TICK_W-1:0] t_long2,
                                   logic [kpd_pkg::TICK_W-1:0] t_long3,
                                   logic [kpd_pkg::TICK_W-1:0] t_long7,
                                   logic [kpd_pkg::TICK_W-1:0] t_timeout);
      write_threshold(kpd_pkg::CSR_SHORT,   t_short);
      write_threshold(kpd_pkg::CSR_LONG1,   t_long1);
      write_threshold(kpd_pkg::CSR_LONG2,   t_long2);
      write_threshold(kpd_pkg::CSR_LONG3,   t_long3);
      write_threshold(kpd_pkg::CSR_LONG7,   t_long7);
      write_threshold(kpd_pkg::CSR_TIMEOUT, t_timeout);
      setting_count++;
      @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // test sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at the reset thresholds (short press is 3 ticks)
      push_item(kpd_pkg::OP_CLEAR, 5'h00, 6'h00);   // empty mask reports all set
      push_item(kpd_pkg::OP_SCAN,  5'h00, 6'h3F);   // idle tick
      push_item(kpd_pkg::OP_SCAN,  5'h01, 6'h00);   // start a single-key press
      repeat (3)
         push_item(kpd_pkg::OP_SCAN, 5'h01, 6'h10); // reach and pass the short mark
      push_item(kpd_pkg::OP_SCAN,  5'h00, 6'h30);   // release: pop
      push_item(kpd_pkg::OP_SCAN,  5'h00, 6'h30);   // popped status holds while idle
      push_item(kpd_pkg::OP_CLEAR, 5'h1F, 6'h3F);   // clear everything
      push_item(kpd_pkg::OP_SCAN,  5'h16, 6'h01);   // chord start from no key
      push_item(kpd_pkg::OP_SCAN,  5'h04, 6'h00);   // second key while held: cancel
      push_item(kpd_pkg::OP_SCAN,  5'h16, 6'h00);   // same vector again: no change
      push_item(kpd_pkg::OP_SCAN,  5'h00, 6'h20);   // release after cancel: no pop
      push_item(kpd_pkg::OP_SCAN,  5'h10, 6'h10);   // lock key, quick press
      push_item(kpd_pkg::OP_SCAN,  5'h10, 6'h10);
      push_item(kpd_pkg::OP_SCAN,  5'h00, 6'h20);   // released too soon for a pop
      push_item(kpd_pkg::OP_SCAN,  5'h1F, 6'h0F);   // all keys at once
      repeat (4)
         push_item(kpd_pkg::OP_SCAN, 5'h1F, 6'h10);
      push_item(kpd_pkg::OP_CLEAR, 5'h0A, 6'h10);   // drop the short flag mid press
      push_item(kpd_pkg::OP_SCAN,  5'h00, 6'h30);   // release: pop
      push_item(kpd_pkg::OP_CLEAR, 5'h00, 6'h3F);
      wait_for_drain();

      // small distinct thresholds, with one long receiver hold-off
      apply_thresholds(16'd2, 16'd4, 16'd6, 16'd9, 16'd12, 16'd15);
      queue_presses(200);
      @(posedge clock);
      hold_kick <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b0;
      wait_for_drain();

      // equal thresholds: the higher flag takes priority
      apply_thresholds(16'd4, 16'd4, 16'd7, 16'd7, 16'd7, 16'd10);
      queue_presses(130);
      wait_for_drain();

      // low extremes: zero thresholds never match, zero timeout trips at once
      apply_thresholds(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 16'd0);
      queue_presses(100);
      wait_for_drain();

      // high extremes: no flag, no pop, no timeout within reach
      apply_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd65534);
      queue_presses(80);
      wait_for_drain();

      // random small thresholds
      apply_thresholds(kpd_pkg::TICK_W'($urandom_range(0, 6)),
                       kpd_pkg::TICK_W'($urandom_range(0, 20)),
                       kpd_pkg::TICK_W'($urandom_range(0, 20)),
                       kpd_pkg::TICK_W'($urandom_range(0, 20)),
                       kpd_pkg::TICK_W'($urandom_range(0, 20)),
                       kpd_pkg::TICK_W'($urandom_range(0, 30)));
      queue_presses(120);
      wait_for_drain();

      repeat (10) @(negedge clock);
      if (report_queue.size() != 0)
         log_failure($sformatf("%0d status items never arrived", report_queue.size()));

      $display("covered %0d items under %0d threshold settings, %0d status items checked",
               items_sent, setting_count, reports_checked);
      $display("presses popped %0d, timed out %0d, cancelled %0d; mismatches %0d",
               pop_count, timeout_count, cancel_count, mismatch_count);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
